FILE: hdl/mcsg_pkg.sv
// ----------------------------------------------------------------------------
// mcsg_pkg
// Shared types and constants for the motion command safety gate.
// ----------------------------------------------------------------------------
package mcsg_pkg;

	localparam int FRAC_BITS  = 4;
	localparam int TICK_WIDTH = 32;
	localparam int SEQ_WIDTH  = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_LEG_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COXA_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_SWEEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FACTOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIT_FREQ    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd5;

	localparam logic [1:0] OP_COMMAND   = 2'd0;
	localparam logic [1:0] OP_ESTOP_SET = 2'd1;
	localparam logic [1:0] OP_ESTOP_CLR = 2'd2;

	localparam logic [2:0] REASON_NONE      = 3'd0;
	localparam logic [2:0] REASON_ESTOPPED  = 3'd1;
	localparam logic [2:0] REASON_OBSTACLE  = 3'd2;
	localparam logic [2:0] REASON_RATE      = 3'd3;
	localparam logic [2:0] REASON_STALE_SEQ = 3'd4;
	localparam logic [2:0] REASON_MALFORMED = 3'd5;

	// divider: 44-bit dividend, 17-bit divisor
	localparam int DIV_W     = 44;
	localparam int DVS_W     = 17;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// square root: 32-bit radicand, 16-bit root
	localparam int SQ_IN_W  = 32;
	localparam int SQ_OUT_W = SQ_IN_W / 2;
	localparam int SQ_CNT_W = $clog2(SQ_OUT_W + 1);

	// x/100 as (x * ceil(2^30/100)) >> 30, exact for x < 2^23
	localparam logic [31:0] RECIP_100   = 32'd10737419;
	localparam int          RECIP_SHIFT = 30;
	localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;

	typedef struct packed {
		logic [1:0]            op;
		logic [SEQ_WIDTH-1:0]  seq_number;
		logic [TICK_WIDTH-1:0] now_ticks;
		logic                  malformed;
		logic                  obstacle_present;
		logic signed [15:0]    req_body_height;
		logic signed [15:0]    req_step_height;
		logic signed [15:0]    req_forward_speed;
		logic signed [15:0]    req_turn_rate;
		logic signed [15:0]    req_max_stride;
	} cmd_item_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         reason;
		logic signed [15:0] out_body_height;
		logic signed [15:0] out_step_height;
		logic signed [15:0] out_forward_speed;
		logic signed [15:0] out_turn_rate;
		logic signed [15:0] out_max_stride;
		logic               was_clamped;
	} res_item_t;

endpackage

FILE: hdl/mcsg_cmd_if.sv
// ----------------------------------------------------------------------------
// mcsg_cmd_if
// Command channel: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface mcsg_cmd_if;
	import mcsg_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mcsg_res_if.sv
// ----------------------------------------------------------------------------
// mcsg_res_if
// Result channel: valid/ready with one gate result item.
// ----------------------------------------------------------------------------
interface mcsg_res_if;
	import mcsg_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mcsg_div.sv
// ----------------------------------------------------------------------------
// mcsg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcsg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mcsg_pkg::DIV_W-1:0] dividend,
	input  logic [mcsg_pkg::DVS_W-1:0] divisor,
	output logic                      busy,
	output logic                      done,
	output logic [mcsg_pkg::DIV_W-1:0] quotient
);
	import mcsg_pkg::*;

	logic [DIV_W-1:0]     work_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       rem_sh;
	logic [DVS_W+1:0]     diff;
	logic                 ge;

	assign rem_sh = {rem_q, work_q[DIV_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], ge};
			rem_q  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = work_q;

endmodule

FILE: hdl/mcsg_sqrt.sv
// ----------------------------------------------------------------------------
// mcsg_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module mcsg_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mcsg_pkg::SQ_IN_W-1:0]  radicand,
	output logic                         done,
	output logic [mcsg_pkg::SQ_OUT_W-1:0] root
);
	import mcsg_pkg::*;

	logic [SQ_IN_W-1:0]  x_q;
	logic [SQ_OUT_W:0]   rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SQ_OUT_W+2:0] rem_sh;
	logic [SQ_OUT_W+3:0] diff;
	logic                ge;

	assign rem_sh = {rem_q, x_q[SQ_IN_W-1 -: 2]};
	assign diff   = {1'b0, rem_sh} - (SQ_OUT_W+4)'({root_q, 2'b01});
	assign ge     = ~diff[SQ_OUT_W+3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(SQ_OUT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? diff[SQ_OUT_W:0] : rem_sh[SQ_OUT_W:0];
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/motion_command_safety_gate_top.sv
// ----------------------------------------------------------------------------
// motion_command_safety_gate_top
// Checks motion commands (estop, malformed, sequence, rate, obstacle) and
// clamps passing commands to leg geometry and gait limits.
// Estop ops: flag updated on the transfer, no result. Rejected command: result
// registered in the cycle after the transfer. Passing command: result after the
// square root and two divides on the shared units (no divides with zero duty),
// then loaded once the result register is free.
// One command in flight; next transfer once the result register is free.
// Reset clears estop, sequence and tick state; config returns to defaults.
// ----------------------------------------------------------------------------
module motion_command_safety_gate_top (
	input  logic                           clk,
	input  logic                           arst_n,
	mcsg_cmd_if.sink                       cmd,
	mcsg_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [mcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mcsg_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MLO  = 4'd1;
	localparam logic [3:0] ST_MHI  = 4'd2;
	localparam logic [3:0] ST_HCL  = 4'd3;
	localparam logic [3:0] ST_MHH  = 4'd4;
	localparam logic [3:0] ST_MLL  = 4'd5;
	localparam logic [3:0] ST_SQS  = 4'd6;
	localparam logic [3:0] ST_SQW  = 4'd7;
	localparam logic [3:0] ST_MSF  = 4'd8;
	localparam logic [3:0] ST_MA   = 4'd9;
	localparam logic [3:0] ST_MK1  = 4'd10;
	localparam logic [3:0] ST_MK2  = 4'd11;
	localparam logic [3:0] ST_QS   = 4'd12;
	localparam logic [3:0] ST_DV1  = 4'd13;
	localparam logic [3:0] ST_DV2  = 4'd14;
	localparam logic [3:0] ST_FIN  = 4'd15;

	logic [15:0] leg_q, coxa_q, freq_q;
	logic [14:0] sweep_q;
	logic [16:0] duty_q;
	logic [30:0] mdi_q;

	logic                  estop_q, seq_valid_q, time_valid_q;
	logic [SEQ_WIDTH-1:0]  last_seq_q;
	logic [TICK_WIDTH-1:0] last_tick_q;
	logic [3:0]            state_q, state_d;

	logic signed [15:0] rb_q, rs_q, rv_q, rw_q, st_q;
	logic [15:0]        lo_q, h_q;
	logic [31:0]        hh_q;
	logic [16:0]        r_q;
	logic [30:0]        sf_q;
	logic [30:0]        a_q;
	logic [42:0]        qh_q;
	logic [DIV_W-1:0]   vmax_q, wmax_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	logic              out_valid_q;
	res_item_t         out_q, fin_item, rej_item;
	logic              out_free, xfer, load_rej, load_fin;
	logic [2:0]        rej_reason;

	logic [SEQ_WIDTH-1:0]  seq_d;
	logic [TICK_WIDTH-1:0] tick_e;
	logic                  seq_ok, rate_ok, upd_seq, upd_tick;

	logic               div_start, div_busy, div_done;
	logic [DIV_W-1:0]   div_dvd, div_quo;
	logic               sq_start, sq_done;
	logic [SQ_OUT_W-1:0] sq_root;

	logic [15:0] hi_w;
	logic [16:0] vsat, wsat;
	logic signed [16:0] rv17, rw17, vlim, wlim;
	logic signed [15:0] step_c, fwd_c, turn_c;

	assign out_free  = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign xfer      = cmd.valid && cmd.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign seq_d   = cmd.data.seq_number - last_seq_q;
	assign seq_ok  = !seq_valid_q || ((seq_d != '0) && !seq_d[SEQ_WIDTH-1]);
	assign tick_e  = cmd.data.now_ticks - last_tick_q;
	assign rate_ok = !time_valid_q
		|| !(tick_e[TICK_WIDTH-1] || (64'(tick_e) < 64'(mdi_q)));

	// check order for a command transfer
	always_comb begin
		load_rej   = 1'b0;
		rej_reason = REASON_NONE;
		upd_seq    = 1'b0;
		upd_tick   = 1'b0;
		if (xfer && cmd.data.op == OP_COMMAND) begin
			priority if (estop_q) begin
				load_rej   = 1'b1;
				rej_reason = REASON_ESTOPPED;
			end else if (cmd.data.malformed) begin
				load_rej   = 1'b1;
				rej_reason = REASON_MALFORMED;
			end else if (!seq_ok) begin
				load_rej   = 1'b1;
				rej_reason = REASON_STALE_SEQ;
			end else if (!rate_ok) begin
				upd_seq    = 1'b1;
				load_rej   = 1'b1;
				rej_reason = REASON_RATE;
			end else if (cmd.data.obstacle_present) begin
				upd_seq    = 1'b1;
				upd_tick   = 1'b1;
				load_rej   = 1'b1;
				rej_reason = REASON_OBSTACLE;
			end else begin
				upd_seq    = 1'b1;
				upd_tick   = 1'b1;
			end
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MLO: begin
				mul_a = 32'(20'(leg_q) * 20'd15 + 20'd50);
				mul_b = RECIP_100;
			end
			ST_MHI: begin
				mul_a = 32'(23'(leg_q) * 23'd95 + 23'd50);
				mul_b = RECIP_100;
			end
			ST_MHH: begin
				mul_a = 32'(h_q);
				mul_b = 32'(h_q);
			end
			ST_MLL: begin
				mul_a = 32'(leg_q);
				mul_b = 32'(leg_q);
			end
			ST_MSF: begin
				mul_a = 32'(sweep_q);
				mul_b = 32'(freq_q);
			end
			ST_MA: begin
				mul_a = 32'(prod_q[30:0]);
				mul_b = 32'(r_q);
			end
			// a = 2*S*F*r: high word is bits 48:31 of S*F*r
			ST_MK1: begin
				mul_a = 32'(prod_q[48:31]);
				mul_b = DEG2RAD_Q32;
			end
			ST_MK2: begin
				mul_a = {a_q, 1'b0};
				mul_b = DEG2RAD_Q32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	assign hi_w = prod_q[RECIP_SHIFT +: 16];

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		sq_start  = 1'b0;
		load_fin  = 1'b0;
		unique case (state_q)
			ST_IDLE: if (xfer && cmd.data.op == OP_COMMAND && !load_rej) state_d = ST_MLO;
			ST_MLO:  state_d = ST_MHI;
			ST_MHI:  state_d = ST_HCL;
			ST_HCL:  state_d = ST_MHH;
			ST_MHH:  state_d = ST_MLL;
			ST_MLL:  state_d = ST_SQS;
			ST_SQS: begin
				sq_start = 1'b1;
				state_d  = ST_SQW;
			end
			ST_SQW:  if (sq_done) state_d = ST_MSF;
			ST_MSF:  state_d = ST_MA;
			ST_MA:   state_d = ST_MK1;
			ST_MK1:  state_d = ST_MK2;
			ST_MK2:  state_d = ST_QS;
			ST_QS: begin
				if (duty_q == '0) begin
					state_d = ST_FIN;
				end else begin
					div_start = 1'b1;
					div_dvd   = DIV_W'(qh_q) + DIV_W'(prod_q[58:32]);
					state_d   = ST_DV1;
				end
			end
			ST_DV1: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = DIV_W'({sf_q, 1'b0}) << FRAC_BITS;
					state_d   = ST_DV2;
				end
			end
			ST_DV2:  if (div_done) state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					load_fin = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			rb_q <= cmd.data.req_body_height;
			rs_q <= cmd.data.req_step_height;
			rv_q <= cmd.data.req_forward_speed;
			rw_q <= cmd.data.req_turn_rate;
			st_q <= cmd.data.req_max_stride;
		end
		if (state_q == ST_MHI) lo_q <= prod_q[RECIP_SHIFT +: 16];
		if (state_q == ST_HCL) begin
			priority if (rb_q < $signed({1'b0, lo_q})) h_q <= lo_q;
			else if (rb_q > $signed({1'b0, hi_w})) h_q <= hi_w;
			else h_q <= rb_q;
		end
		if (state_q == ST_MLL) hh_q <= prod_q[31:0];
		if (state_q == ST_SQW && sq_done) r_q <= 17'(coxa_q) + 17'(sq_root);
		if (state_q == ST_MA)  sf_q <= prod_q[30:0];
		if (state_q == ST_MK1) a_q  <= prod_q[30:0];
		if (state_q == ST_MK2) qh_q <= prod_q[42:0];
		if (state_q == ST_QS && duty_q == '0) begin
			vmax_q <= '0;
			wmax_q <= '0;
		end
		if (state_q == ST_DV1 && div_done) vmax_q <= div_quo;
		if (state_q == ST_DV2 && div_done) wmax_q <= div_quo;
	end

	mcsg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (prod_q[31:0] - hh_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	mcsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (duty_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// limits saturate at 2^15 so the full request range stays reachable
	assign vsat = (vmax_q > DIV_W'(32768)) ? 17'd32768 : vmax_q[16:0];
	assign wsat = (wmax_q > DIV_W'(32768)) ? 17'd32768 : wmax_q[16:0];
	assign vlim = $signed(vsat);
	assign wlim = $signed(wsat);
	assign rv17 = 17'(rv_q);
	assign rw17 = 17'(rw_q);

	always_comb begin
		priority if (rs_q < 16'sd0) step_c = 16'sd0;
		else if (rs_q > $signed(h_q)) step_c = $signed(h_q);
		else step_c = rs_q;
		priority if (rv17 > vlim) fwd_c = 16'(vlim);
		else if (rv17 < -vlim) fwd_c = 16'(-vlim);
		else fwd_c = rv_q;
		priority if (rw17 > wlim) turn_c = 16'(wlim);
		else if (rw17 < -wlim) turn_c = 16'(-wlim);
		else turn_c = rw_q;
	end

	always_comb begin
		fin_item.accepted          = 1'b1;
		fin_item.reason            = REASON_NONE;
		fin_item.out_body_height   = $signed(h_q);
		fin_item.out_step_height   = step_c;
		fin_item.out_forward_speed = fwd_c;
		fin_item.out_turn_rate     = turn_c;
		fin_item.out_max_stride    = st_q;
		fin_item.was_clamped       = ($signed(h_q) != rb_q) || (step_c != rs_q)
			|| (fwd_c != rv_q) || (turn_c != rw_q);
	end

	always_comb begin
		rej_item        = '0;
		rej_item.reason = rej_reason;
	end

	always_ff @(posedge clk) begin
		if (load_fin) begin
			out_q <= fin_item;
		end else if (load_rej) begin
			out_q <= rej_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			estop_q      <= 1'b0;
			seq_valid_q  <= 1'b0;
			last_seq_q   <= '0;
			time_valid_q <= 1'b0;
			last_tick_q  <= '0;
			leg_q        <= 16'd1600;
			coxa_q       <= 16'd480;
			sweep_q      <= 15'd7680;
			duty_q       <= 17'd32768;
			freq_q       <= 16'd512;
			mdi_q        <= '0;
		end else begin
			state_q <= state_d;
			if (load_fin || load_rej) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			if (xfer && cmd.data.op == OP_ESTOP_SET) estop_q <= 1'b1;
			if (xfer && cmd.data.op == OP_ESTOP_CLR) estop_q <= 1'b0;
			if (upd_seq) begin
				seq_valid_q <= 1'b1;
				last_seq_q  <= cmd.data.seq_number;
			end
			if (upd_tick) begin
				time_valid_q <= 1'b1;
				last_tick_q  <= cmd.data.now_ticks;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LEG_LENGTH:   leg_q   <= cfg_wdata[15:0];
					CFG_COXA_LENGTH:  coxa_q  <= cfg_wdata[15:0];
					CFG_HALF_SWEEP:   sweep_q <= cfg_wdata[14:0];
					CFG_DUTY_FACTOR:  duty_q  <= cfg_wdata[16:0];
					CFG_GAIT_FREQ:    freq_q  <= cfg_wdata[15:0];
					CFG_MIN_INTERVAL: mdi_q   <= cfg_wdata[30:0];
					default: ;
				endcase
			end
		end
	end

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.accepted) |-> (out_q.out_body_height == 16'sd0
		&& out_q.out_forward_speed == 16'sd0 && out_q.out_max_stride == 16'sd0
		&& !out_q.was_clamped && out_q.reason != REASON_NONE))
		else $error("rejected result carries payload");

	a_acc_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.accepted) |-> (out_q.reason == REASON_NONE
		&& out_q.out_step_height >= 16'sd0
		&& out_q.out_step_height <= out_q.out_body_height))
		else $error("accepted result out of range");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_estop: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && cmd.data.op == OP_ESTOP_SET) |=> estop_q)
		else $error("estop not latched");

	a_estop_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && cmd.data.op == OP_COMMAND && estop_q) |=>
		(out_valid_q && out_q.reason == REASON_ESTOPPED && state_q == ST_IDLE))
		else $error("command passed while estopped");

endmodule
